// ----- design/subpicture_rle_run_decoder_macros.svh -----
// Assertion macros shared by the subpicture run decoder.
`ifndef SUBPICTURE_RLE_RUN_DECODER_MACROS_SVH
`define SUBPICTURE_RLE_RUN_DECODER_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define SRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/srd_pkg.sv -----
// Types and constants of the subpicture run-length decoder.
`default_nettype none

package srd_pkg;

  localparam int unsigned MaxLineWidth = 4096;
  localparam int unsigned WidthW       = 13;
  localparam int unsigned ColW         = 12;
  localparam int unsigned LineW        = 12;
  localparam int unsigned RowW         = 12;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  localparam logic [WidthW-1:0] LineWidthReset  = 13'd720;
  localparam logic [LineW-1:0]  FieldLinesReset = 12'd288;

  // Thresholds that end a code after one, two and three nibbles, and the
  // four-nibble value below which a code fills the rest of the line.
  localparam logic [9:0] CodeMin1 = 10'h004;
  localparam logic [9:0] CodeMin2 = 10'h010;
  localparam logic [9:0] CodeMin3 = 10'h040;
  localparam logic [9:0] CodeFill = 10'h100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLineWidth  = 3'd0,
    CfgFieldLines = 3'd1,
    CfgColorMap   = 3'd2,
    CfgAlphaMap   = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [5:0]       accum;
    logic [1:0]       cnt;
    logic [ColW-1:0]  column;
    logic [LineW-1:0] line;
  } dec_state_t;

  typedef struct packed {
    logic [WidthW-1:0] run_length;
    logic [3:0]        pixel_color;
    logic [3:0]        pixel_alpha;
    logic [ColW-1:0]   run_column;
    logic [RowW-1:0]   picture_row;
    logic              row_dirty;
    logic              line_end;
    logic              last_of_byte;
  } result_t;

  typedef struct packed {
    dec_state_t st;
    logic       valid;
    logic       line_done;
    result_t    res;
  } feed_t;

endpackage

`default_nettype wire

// ----- design/srd_if.sv -----
// Channel interfaces of the subpicture run-length decoder.
`default_nettype none

interface srd_rle_if
  import srd_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] rle_byte;
  logic       field_start;
  logic       field_select;

  modport source (output valid, rle_byte, field_start, field_select, input ready);
  modport sink   (input valid, rle_byte, field_start, field_select, output ready);
endinterface

interface srd_run_if
  import srd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WidthW-1:0] run_length;
  logic [3:0]        pixel_color;
  logic [3:0]        pixel_alpha;
  logic [ColW-1:0]   run_column;
  logic [RowW-1:0]   picture_row;
  logic              row_dirty;
  logic              line_end;
  logic              last_of_byte;

  modport source (output valid, run_length, pixel_color, pixel_alpha, run_column,
                  picture_row, row_dirty, line_end, last_of_byte, input ready);
  modport sink   (input valid, run_length, pixel_color, pixel_alpha, run_column,
                  picture_row, row_dirty, line_end, last_of_byte, output ready);
endinterface

interface srd_cfg_if
  import srd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ----- design/subpicture_rle_run_decoder.sv -----
// A run enters the result queue when its byte is accepted and leaves it behind
// any runs still waiting. Throughput: one byte per cycle while two queue entries
// are free and one run per cycle while the receiver is ready; both nibbles of a
// byte are decoded in the accepting cycle, and a byte giving two runs leaves the
// result queue's single output port one run at a time. Reset: decode state and
// the queue clear at once, registers take their defaults; no clearing pass.
`default_nettype none

module subpicture_rle_run_decoder
  import srd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  srd_cfg_if.sink      cfg_i,
  srd_rle_if.sink      rle_i,
  srd_run_if.source    run_o
);

`include "subpicture_rle_run_decoder_macros.svh"

  // Decodes one nibble against the given state. A nibble either extends the
  // partial code or completes it and yields a run. Once the field has all of
  // its lines, nibbles are ignored and the partial code is kept.
  function automatic feed_t feed_nibble(
    input dec_state_t        st,
    input logic [3:0]        nib,
    input logic              fsel,
    input logic [WidthW-1:0] w,
    input logic [LineW-1:0]  flines,
    input logic [15:0]       cmap,
    input logic [15:0]       amap
  );
    feed_t             f;
    logic [9:0]        acc;
    logic [2:0]        cnt;
    logic              done;
    logic [WidthW-1:0] remain;
    logic [WidthW-1:0] run;
    logic [WidthW:0]   endpos;
    logic [1:0]        v;
    f      = '0;
    f.st   = st;
    acc    = {st.accum, nib};
    cnt    = {1'b0, st.cnt} + 3'd1;
    remain = '0;
    run    = '0;
    endpos = '0;
    v      = acc[1:0];
    case (cnt)
      3'd1:    done = (acc >= CodeMin1);
      3'd2:    done = (acc >= CodeMin2);
      3'd3:    done = (acc >= CodeMin3);
      default: done = 1'b1;
    endcase
    if (st.line < flines) begin
      if (!done) begin
        // An unfinished code is below 0x40, so six bits hold it.
        f.st.accum = acc[5:0];
        f.st.cnt   = cnt[1:0];
      end else begin
        f.st.accum = '0;
        f.st.cnt   = '0;
        remain = ({1'b0, st.column} < w) ? (w - {1'b0, st.column}) : WidthW'(1);
        run    = {5'd0, acc[9:2]};
        if ((cnt == 3'd4 && acc < CodeFill) || run == '0 || run > remain) begin
          run = remain;
        end
        f.valid           = 1'b1;
        f.res.run_length  = run;
        // Colour index 3-v selects the entry at bits 4v+3 down to 4v.
        f.res.pixel_color = cmap[{v, 2'b00} +: 4];
        f.res.pixel_alpha = amap[{v, 2'b00} +: 4];
        f.res.run_column  = st.column;
        f.res.picture_row = {st.line[LineW-2:0], fsel};
        f.res.row_dirty   = (run != w);
        endpos = {2'b00, st.column} + {1'b0, run};
        if (endpos >= {1'b0, w}) begin
          f.res.line_end = 1'b1;
          f.line_done    = 1'b1;
          f.st.column    = '0;
          f.st.line      = st.line + LineW'(1);
        end else begin
          f.st.column = endpos[ColW-1:0];
        end
      end
    end
    return f;
  endfunction

  // Configuration registers. Writes are always taken; an index beyond the
  // register list is dropped.
  logic [WidthW-1:0] line_width_q;
  logic [LineW-1:0]  field_lines_q;
  logic [15:0]       color_map_q;
  logic [15:0]       alpha_map_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q  <= LineWidthReset;
      field_lines_q <= FieldLinesReset;
      color_map_q   <= '0;
      alpha_map_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.reg_index))
        CfgLineWidth:  line_width_q  <= cfg_i.wdata[WidthW-1:0];
        CfgFieldLines: field_lines_q <= cfg_i.wdata[LineW-1:0];
        CfgColorMap:   color_map_q   <= cfg_i.wdata;
        CfgAlphaMap:   alpha_map_q   <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // The programmed width is clamped to the range one to the maximum.
  logic [WidthW-1:0] eff_width;
  always_comb begin
    if (line_width_q == '0) begin
      eff_width = WidthW'(1);
    end else if (line_width_q > WidthW'(MaxLineWidth)) begin
      eff_width = WidthW'(MaxLineWidth);
    end else begin
      eff_width = line_width_q;
    end
  end

  // Decode state and the two-nibble decode of the incoming byte.
  dec_state_t state_q, state_d;
  dec_state_t st_cur;
  feed_t      f_hi, f_lo;
  logic       use_lo;
  logic       in_fire;

  always_comb begin
    st_cur = rle_i.field_start ? dec_state_t'('0) : state_q;
    f_hi   = feed_nibble(st_cur, rle_i.rle_byte[7:4], rle_i.field_select, eff_width,
                         field_lines_q, color_map_q, alpha_map_q);
    f_lo   = feed_nibble(f_hi.st, rle_i.rle_byte[3:0], rle_i.field_select, eff_width,
                         field_lines_q, color_map_q, alpha_map_q);
    // The low nibble is dropped when the high nibble completes the line.
    use_lo  = !f_hi.line_done;
    state_d = use_lo ? f_lo.st : f_hi.st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Results of this byte in order, with the last one flagged.
  result_t   push_a, push_b;
  logic [1:0] push_n;

  always_comb begin
    push_a = f_hi.res;
    push_b = f_lo.res;
    push_n = 2'd0;
    if (f_hi.valid && use_lo && f_lo.valid) begin
      push_n              = 2'd2;
      push_a.last_of_byte = 1'b0;
      push_b.last_of_byte = 1'b1;
    end else if (f_hi.valid) begin
      push_n              = 2'd1;
      push_a.last_of_byte = 1'b1;
    end else if (use_lo && f_lo.valid) begin
      push_n              = 2'd1;
      push_a              = f_lo.res;
      push_a.last_of_byte = 1'b1;
    end
  end

  // Result queue. A byte is taken only while two entries are free, so a
  // waiting result never stops the next byte unless the queue is backed up.
  result_t              queue_q [QueueDepth];
  logic [QueuePtrW-1:0] head_q;
  logic [QueueCntW-1:0] count_q;
  logic [QueuePtrW-1:0] tail0, tail1;
  logic                 pop;

  assign rle_i.ready = (count_q <= QueueCntW'(QueueDepth - 2));
  assign in_fire     = rle_i.valid && rle_i.ready;
  assign pop         = run_o.valid && run_o.ready;
  assign tail0       = head_q + count_q[QueuePtrW-1:0];
  assign tail1       = tail0 + QueuePtrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      if (pop) begin
        head_q <= head_q + QueuePtrW'(1);
      end
      count_q <= count_q + (in_fire ? QueueCntW'(push_n) : QueueCntW'(0))
               - (pop ? QueueCntW'(1) : QueueCntW'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && push_n != 2'd0) begin
      queue_q[tail0] <= push_a;
    end
    if (in_fire && push_n == 2'd2) begin
      queue_q[tail1] <= push_b;
    end
  end

  result_t head_res;
  assign head_res = queue_q[head_q];

  assign run_o.valid        = (count_q != '0);
  assign run_o.run_length   = head_res.run_length;
  assign run_o.pixel_color  = head_res.pixel_color;
  assign run_o.pixel_alpha  = head_res.pixel_alpha;
  assign run_o.run_column   = head_res.run_column;
  assign run_o.picture_row  = head_res.picture_row;
  assign run_o.row_dirty    = head_res.row_dirty;
  assign run_o.line_end     = head_res.line_end;
  assign run_o.last_of_byte = head_res.last_of_byte;

  // The queue never holds more than its depth.
  `SRD_ASSERT(a_queue_bound, count_q <= QueueCntW'(QueueDepth), "result queue overflow")
  // With two runs from one byte, the first cannot have ended the line.
  `SRD_ASSERT(a_two_runs_mid_line, !(in_fire && push_n == 2'd2) || !push_a.line_end,
              "second run decoded after line end")
  // A completed line restarts at column zero.
  `SRD_ASSERT_NEXT(a_line_restart, in_fire && (f_hi.line_done || (use_lo && f_lo.line_done)),
                   state_q.column == '0, "column not cleared after line end")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the subpicture run-length decoder.
`timescale 1ns / 100ps

module tb
  import srd_pkg::*;
();

  // Cycles without any transaction before the run is declared hung. The worst
  // legitimate quiet stretch is a long random stall plus the short hold-off
  // before a register write, far below this.
  localparam int unsigned QuietLimit = 2000;
  // Cycles left after the last expected run before registers are rewritten.
  localparam int unsigned HoldOff = 3;
  // Register indexes that map to no register at all.
  localparam int unsigned FirstUnusedIdx = CfgAlphaMap + 1;
  localparam int unsigned LastUnusedIdx = (1 << CfgIdxW) - 1;

  logic clk_i = 1'b0;
  logic rst_ni;

  srd_cfg_if cfg_bus();
  srd_rle_if rle_bus();
  srd_run_if run_bus();

  subpicture_rle_run_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .rle_i  (rle_bus),
    .run_o  (run_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Percentages of cycles in which the byte sender holds back and the run
  // receiver refuses a transaction.
  int unsigned byte_gap_pct;
  int unsigned run_stall_pct;

  // Our own copy of the registers and the decode state.
  logic [WidthW-1:0] cfg_width;
  logic [LineW-1:0]  cfg_lines;
  logic [15:0]       color_map_q;
  logic [15:0]       alpha_map_q;
  logic [15:0]       code_acc;
  logic [1:0]        code_len;
  logic [ColW-1:0]   col_pos;
  logic [LineW-1:0]  line_count;

  result_t     expected_runs[$];
  result_t     oldest_run;
  result_t     seen_run;
  int unsigned mismatches = 0;

  // The receiver stalls at random; with a zero percentage it never stalls.
  always @(posedge clk_i) begin
    run_bus.ready <= ($urandom_range(99, 0) >= run_stall_pct);
  end

  // Widths of zero and above the maximum are clamped before use.
  function automatic int unsigned active_width();
    if (cfg_width == '0) return 1;
    if (cfg_width > MaxLineWidth) return MaxLineWidth;
    return cfg_width;
  endfunction

  // Adds one nibble to the code being collected. Once the code is complete
  // the run it describes is returned, and the column and line advance.
  function automatic void decode_nibble(input logic [3:0] nib, input logic sel,
                                        output logic produced, output logic ended,
                                        output result_t res);
    int unsigned w, acc, len, remain, run_len, idx;
    logic complete;
    w = active_width();
    produced = 1'b0;
    ended = 1'b0;
    res = '0;
    // A finished field ignores everything, and any partial code is kept.
    if (line_count >= cfg_lines) return;
    acc = ((code_acc << 4) | nib) & 16'hFFFF;
    len = code_len + 1;
    case (len)
      1: complete = (acc >= CodeMin1);
      2: complete = (acc >= CodeMin2);
      3: complete = (acc >= CodeMin3);
      default: complete = 1'b1;
    endcase
    if (!complete) begin
      code_acc = acc[15:0];
      code_len = len[1:0];
      return;
    end
    code_acc = '0;
    code_len = '0;
    // A column left beyond a narrowed line gives a single closing pixel.
    remain = (col_pos < w) ? (w - col_pos) : 1;
    run_len = acc >> 2;
    // Short four-nibble codes and zero or overlong runs fill the line.
    if (len == 4 && acc < CodeFill) run_len = remain;
    if (run_len == 0 || run_len > remain) run_len = remain;
    idx = 3 - (acc & 3);
    res.run_length  = run_len[WidthW-1:0];
    res.pixel_color = color_map_q[15 - 4 * idx -: 4];
    res.pixel_alpha = alpha_map_q[15 - 4 * idx -: 4];
    res.run_column  = col_pos;
    res.picture_row = {line_count[LineW-2:0], sel};
    res.row_dirty   = (run_len != w);
    if (col_pos + run_len >= w) begin
      res.line_end = 1'b1;
      col_pos = '0;
      line_count = line_count + 1'b1;
      ended = 1'b1;
    end else begin
      col_pos = col_pos + run_len[ColW-1:0];
    end
    produced = 1'b1;
  endfunction

  // Works out the runs of one accepted byte and queues them. A line that
  // completes on the high nibble drops the low one.
  function automatic void decode_byte(input logic [7:0] data, input logic start,
                                      input logic sel);
    result_t hi_run, lo_run;
    logic hi_got, hi_end, lo_got, lo_end;
    if (start) begin
      code_acc = '0;
      code_len = '0;
      col_pos = '0;
      line_count = '0;
    end
    decode_nibble(data[7:4], sel, hi_got, hi_end, hi_run);
    lo_got = 1'b0;
    if (!hi_end) decode_nibble(data[3:0], sel, lo_got, lo_end, lo_run);
    if (lo_got) lo_run.last_of_byte = 1'b1;
    else hi_run.last_of_byte = 1'b1;
    if (hi_got) expected_runs.push_back(hi_run);
    if (lo_got) expected_runs.push_back(lo_run);
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // One process watches all three channels. The run channel is checked
  // before the byte of the same edge is decoded; a run never leaves in the
  // cycle its byte arrives, so the order only matters for readability.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width = LineWidthReset;
      cfg_lines = FieldLinesReset;
      color_map_q = '0;
      alpha_map_q = '0;
      code_acc = '0;
      code_len = '0;
      col_pos = '0;
      line_count = '0;
      expected_runs.delete();
    end else begin
      if (run_bus.valid && run_bus.ready) begin
        seen_run.run_length   = run_bus.run_length;
        seen_run.pixel_color  = run_bus.pixel_color;
        seen_run.pixel_alpha  = run_bus.pixel_alpha;
        seen_run.run_column   = run_bus.run_column;
        seen_run.picture_row  = run_bus.picture_row;
        seen_run.row_dirty    = run_bus.row_dirty;
        seen_run.line_end     = run_bus.line_end;
        seen_run.last_of_byte = run_bus.last_of_byte;
        if (expected_runs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected run, expected none, actual %p", $time, seen_run);
        end else begin
          oldest_run = expected_runs.pop_front();
          compare_field("run_length", oldest_run.run_length, seen_run.run_length);
          compare_field("pixel_color", oldest_run.pixel_color, seen_run.pixel_color);
          compare_field("pixel_alpha", oldest_run.pixel_alpha, seen_run.pixel_alpha);
          compare_field("run_column", oldest_run.run_column, seen_run.run_column);
          compare_field("picture_row", oldest_run.picture_row, seen_run.picture_row);
          compare_field("row_dirty", oldest_run.row_dirty, seen_run.row_dirty);
          compare_field("line_end", oldest_run.line_end, seen_run.line_end);
          compare_field("last_of_byte", oldest_run.last_of_byte, seen_run.last_of_byte);
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        // Writes to indexes beyond the register list are dropped.
        case (cfg_bus.reg_index)
          CfgLineWidth:  cfg_width = cfg_bus.wdata[WidthW-1:0];
          CfgFieldLines: cfg_lines = cfg_bus.wdata[LineW-1:0];
          CfgColorMap:   color_map_q = cfg_bus.wdata;
          CfgAlphaMap:   alpha_map_q = cfg_bus.wdata;
          default: ;
        endcase
      end
      if (rle_bus.valid && rle_bus.ready)
        decode_byte(rle_bus.rle_byte, rle_bus.field_start, rle_bus.field_select);
    end
  end

  // Ends a hung run: every cycle with no transaction on any channel counts.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (rle_bus.valid && rle_bus.ready) || (run_bus.valid && run_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Offers one byte. Valid stays high from one byte to the next unless a gap
  // is drawn, so it is never lowered and raised again in the same step.
  task automatic send_byte(input logic [7:0] data, input logic start, input logic sel);
    while ($urandom_range(99, 0) < byte_gap_pct) begin
      rle_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    rle_bus.valid <= 1'b1;
    rle_bus.rle_byte <= data;
    rle_bus.field_start <= start;
    rle_bus.field_select <= sel;
    @(posedge clk_i);
    while (!rle_bus.ready) @(posedge clk_i);
  endtask

  // Stops the byte stream and waits until every expected run has been taken,
  // then waits out the hold-off in case the last byte is still being worked on.
  task automatic drain_runs();
    rle_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (HoldOff) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Decoding straight out of reset: default width, lines and empty maps.
  task automatic test_reset_values();
    send_byte(8'h5C, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    drain_runs();
  endtask

  // Distinct map entries show which index each colour value picks. Writes
  // of zero to the unused indexes must leave every register alone.
  task automatic test_register_map();
    write_reg(CfgColorMap, 16'h1234);
    write_reg(CfgAlphaMap, 16'hFEDC);
    for (int unsigned idx = FirstUnusedIdx; idx <= LastUnusedIdx; idx++)
      write_reg(CfgIdxW'(idx), '0);
    send_byte(8'h45, 1'b1, 1'b1);
    send_byte(8'h67, 1'b0, 1'b0);
    drain_runs();
  endtask

  // Codes of one to four nibbles, a fill that completes on a high nibble so
  // that the low one is dropped, an overlong run and a zero code filling a
  // whole line.
  task automatic test_code_lengths();
    write_reg(CfgLineWidth, 16'd64);
    write_reg(CfgFieldLines, 16'd4);
    send_byte(8'h40, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h0F, 1'b0, 1'b1);
    send_byte(8'h12, 1'b0, 1'b1);
    send_byte(8'h04, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    drain_runs();
  endtask

  // A width of zero behaves as one pixel, and a width above the maximum as
  // the maximum. The spare data bits above the register are set as well.
  task automatic test_width_extremes();
    write_reg(CfgLineWidth, 16'hE000);
    send_byte(8'h5C, 1'b1, 1'b0);
    drain_runs();
    write_reg(CfgLineWidth, 16'hFFFF);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    drain_runs();
  endtask

  // The width drops below the current column in mid-line; the next run is
  // a single pixel that closes the line.
  task automatic test_width_shrink();
    write_reg(CfgLineWidth, 16'd720);
    write_reg(CfgFieldLines, 16'd288);
    send_byte(8'h0F, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    drain_runs();
    write_reg(CfgLineWidth, 16'd10);
    send_byte(8'h4C, 1'b0, 1'b0);
    drain_runs();
  endtask

  // A partial code survives a spell in which the field counts as finished,
  // and completes once more lines are allowed.
  task automatic test_field_end();
    write_reg(CfgLineWidth, 16'd4);
    write_reg(CfgFieldLines, 16'd4);
    send_byte(8'h00, 1'b1, 1'b1);
    drain_runs();
    write_reg(CfgFieldLines, 16'd0);
    send_byte(8'h55, 1'b0, 1'b1);
    drain_runs();
    write_reg(CfgFieldLines, 16'd4);
    send_byte(8'h0F, 1'b0, 1'b1);
    drain_runs();
    write_reg(CfgFieldLines, 16'd1);
    send_byte(8'hA5, 1'b0, 1'b1);
    drain_runs();
    write_reg(CfgFieldLines, 16'hFFFF);
    send_byte(8'h12, 1'b0, 1'b1);
    drain_runs();
  endtask

  // Draws a new setting of all four registers, extremes included, with junk
  // in the unused data bits and now and then a write to an unused index.
  task automatic pick_settings();
    logic [WidthW-1:0] w;
    logic [LineW-1:0]  lines;
    logic [15:0]       colors, alphas;
    case ($urandom_range(9, 0))
      0: w = '0;
      1: w = 13'd1;
      2: w = WidthW'(MaxLineWidth);
      3: w = '1;
      4, 5: w = WidthW'($urandom_range(16, 2));
      6, 7: w = WidthW'($urandom_range(100, 17));
      default: w = WidthW'($urandom_range(400, 101));
    endcase
    case ($urandom_range(7, 0))
      0: lines = '0;
      1: lines = '1;
      2: lines = 12'd1;
      default: lines = LineW'($urandom_range(6, 2));
    endcase
    colors = ($urandom_range(7, 0) == 0) ? 16'hFFFF : 16'($urandom_range(65535, 0));
    alphas = ($urandom_range(7, 0) == 0) ? 16'h0000 : 16'($urandom_range(65535, 0));
    write_reg(CfgLineWidth, {3'($urandom_range(7, 0)), w});
    write_reg(CfgFieldLines, {4'($urandom_range(15, 0)), lines});
    write_reg(CfgColorMap, colors);
    write_reg(CfgAlphaMap, alphas);
    if ($urandom_range(3, 0) == 0)
      write_reg(CfgIdxW'($urandom_range(LastUnusedIdx, FirstUnusedIdx)),
                16'($urandom_range(65535, 0)));
  endtask

  // One field of well-formed code: random runs and colours, each line padded
  // to a byte boundary where it ends, stopping when the field is full or the
  // byte budget runs out. A few bytes are corrupted, and some random bytes
  // follow, which a finished field ignores.
  task automatic send_field(output int unsigned sent);
    logic [3:0]  nibs[$];
    logic [7:0]  data;
    logic        sel, first;
    int unsigned w, col, lines_done, cap, run_len, code, n, remain;
    w = active_width();
    sel = 1'($urandom_range(1, 0));
    first = 1'b1;
    cap = $urandom_range(40, 6);
    col = 0;
    lines_done = 0;
    sent = 0;
    while (sent < cap && lines_done < cfg_lines) begin
      while (nibs.size() < 2) begin
        remain = w - col;
        case ($urandom_range(7, 0))
          0: run_len = 0;
          1: run_len = remain;
          2, 3: run_len = $urandom_range(3, 1);
          4: run_len = $urandom_range(15, 4);
          5: run_len = $urandom_range(63, 16);
          default: run_len = $urandom_range(255, 64);
        endcase
        if (run_len == 0 || run_len > 255) begin
          // Four nibbles below the fill threshold: the rest of the line.
          code = $urandom_range(63, 0);
          n = 4;
        end else begin
          code = (run_len << 2) | $urandom_range(3, 0);
          n = (run_len < 4) ? 1 : (run_len < 16) ? 2 : (run_len < 64) ? 3 : 4;
        end
        for (int unsigned i = n; i > 0; i--) nibs.push_back(code[4 * i - 1 -: 4]);
        if (run_len == 0 || run_len >= remain) begin
          col = 0;
          lines_done++;
          if (nibs.size() % 2 != 0) nibs.push_back(4'($urandom_range(15, 0)));
        end else begin
          col += run_len;
        end
      end
      data = {nibs[0], nibs[1]};
      void'(nibs.pop_front());
      void'(nibs.pop_front());
      if ($urandom_range(24, 0) == 0) data = 8'($urandom_range(255, 0));
      send_byte(data, first, sel);
      first = 1'b0;
      sent++;
    end
    repeat ($urandom_range(3, 1)) begin
      send_byte(8'($urandom_range(255, 0)), first, sel);
      first = 1'b0;
      sent++;
    end
  endtask

  // Plain random bytes with the odd field start among them.
  task automatic send_noise(output int unsigned sent);
    sent = $urandom_range(20, 4);
    repeat (sent)
      send_byte(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0,
                1'($urandom_range(1, 0)));
  endtask

  // Mostly well-formed fields, some noise, and new settings now and then;
  // each change of settings first lets all outstanding runs drain.
  task automatic test_random_fields(input int unsigned byte_budget);
    int unsigned total, sent;
    total = 0;
    while (total < byte_budget) begin
      if ($urandom_range(1, 0) == 1) begin
        drain_runs();
        pick_settings();
      end
      if ($urandom_range(99, 0) < 15) send_noise(sent);
      else send_field(sent);
      total += sent;
    end
    drain_runs();
  endtask

  initial begin
    rst_ni = 1'b0;
    rle_bus.valid = 1'b0;
    rle_bus.rle_byte = '0;
    rle_bus.field_start = 1'b0;
    rle_bus.field_select = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.reg_index = '0;
    cfg_bus.wdata = '0;
    byte_gap_pct = 31;
    run_stall_pct = 74;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_register_map();
    test_code_lengths();
    test_width_extremes();
    test_width_shrink();
    test_field_end();
    test_random_fields(217);

    // Now a slow sender against an eager receiver, then no idling at all.
    byte_gap_pct = 74;
    run_stall_pct = 31;
    test_random_fields(217);
    byte_gap_pct = 0;
    run_stall_pct = 0;
    test_random_fields(216);

    drain_runs();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_runs.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
